// ----- hdl/rwtc_pkg.sv -----
// shared widths, codes and handshake structs for the wall texture column mapper
`default_nettype none

package rwtc_pkg;

    localparam int TEX_SIZE_DEF  = 64;
    localparam int SCREEN_HEIGHT = 1024;

    localparam int POS_W      = 24;
    localparam int DIR_W      = 18;
    localparam int DIST_W     = 24;
    localparam int ROW_W      = 10;
    localparam int HEIGHT_W   = 16;
    localparam int COL_W      = 11;
    localparam int SEL_W      = 2;
    localparam int TEXEL_W    = 12;
    localparam int FRAC_W     = 16;
    localparam int HIT_W      = 2 * FRAC_W;
    localparam int FACTOR_W   = 17;
    localparam int REM_W      = HEIGHT_W + 1;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 24;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PLAYER_POS_X = 1'b0,
        REG_PLAYER_POS_Y = 1'b1
    } t_cfg_reg;

    typedef enum logic {
        KIND_LOAD = 1'b0,
        KIND_TICK = 1'b1
    } t_kind;

    typedef enum logic [SEL_W-1:0] {
        TEX_EAST  = 2'd0,
        TEX_WEST  = 2'd1,
        TEX_SOUTH = 2'd2,
        TEX_NORTH = 2'd3
    } t_tex_id;

    typedef struct packed {
        logic load;
        logic mul;
        logic div_step;
        logic finish;
        logic tick;
    } t_dp_cmd;

    typedef struct packed {
        logic active;
        logic div_last;
        logic out_free;
    } t_dp_status;

endpackage

`default_nettype wire

// ----- hdl/rwtc_in_if.sv -----
// input channel: column loads and pixel ticks
`default_nettype none

interface rwtc_in_if;
    import rwtc_pkg::*;

    logic                    valid;
    logic                    ready;
    logic                    kind;
    logic                    hit_side;
    logic signed [DIR_W-1:0] ray_dir_x;
    logic signed [DIR_W-1:0] ray_dir_y;
    logic [DIST_W-1:0]       wall_dist;
    logic [ROW_W-1:0]        span_start;
    logic [ROW_W-1:0]        span_end;
    logic [HEIGHT_W-1:0]     wall_height;
    logic [COL_W-1:0]        screen_col;

    modport source (
        output valid, kind, hit_side, ray_dir_x, ray_dir_y, wall_dist,
               span_start, span_end, wall_height, screen_col,
        input  ready
    );

    modport sink (
        input  valid, kind, hit_side, ray_dir_x, ray_dir_y, wall_dist,
               span_start, span_end, wall_height, screen_col,
        output ready
    );
endinterface

`default_nettype wire

// ----- hdl/rwtc_out_if.sv -----
// output channel: one texel address per pixel
`default_nettype none

interface rwtc_out_if;
    import rwtc_pkg::*;

    logic               valid;
    logic               ready;
    logic [SEL_W-1:0]   texture_id;
    logic [TEXEL_W-1:0] texel_index;
    logic [COL_W-1:0]   pixel_x;
    logic [ROW_W-1:0]   pixel_y;
    logic               last;

    modport source (
        output valid, texture_id, texel_index, pixel_x, pixel_y, last,
        input  ready
    );

    modport sink (
        input  valid, texture_id, texel_index, pixel_x, pixel_y, last,
        output ready
    );
endinterface

`default_nettype wire

// ----- hdl/rwtc_ctrl.sv -----
// controller: accepts items and sequences the column load
`default_nettype none

module rwtc_ctrl (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_valid,
    input  wire                  i_kind,
    output logic                 o_ready,
    input  rwtc_pkg::t_dp_status i_status,
    output rwtc_pkg::t_dp_cmd    o_cmd
);
    import rwtc_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_DIV,
        S_POS
    } t_state;

    t_state r_state;
    logic   accept;

    assign o_ready = (r_state == S_IDLE) && (!i_status.active || i_status.out_free);
    assign accept  = i_valid && o_ready;

    always_comb begin
        o_cmd          = '0;
        o_cmd.load     = accept && (t_kind'(i_kind) == KIND_LOAD);
        o_cmd.tick     = accept && (t_kind'(i_kind) == KIND_TICK) && i_status.active;
        o_cmd.mul      = (r_state == S_MUL);
        o_cmd.div_step = (r_state == S_DIV);
        o_cmd.finish   = (r_state == S_POS);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (o_cmd.load) begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (i_status.div_last) begin
                        r_state <= S_POS;
                    end
                end
                S_POS: begin
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end
endmodule

`default_nettype wire

// ----- hdl/rwtc_datapath.sv -----
// datapath: hit fraction, step divider, texture position and output register
`default_nettype none

module rwtc_datapath #(
    parameter int TEX_SIZE = rwtc_pkg::TEX_SIZE_DEF
) (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   i_cfg_we,
    input  wire  [rwtc_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  wire  [rwtc_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    input  rwtc_pkg::t_dp_cmd                     i_cmd,
    output rwtc_pkg::t_dp_status                  o_status,
    input  wire                                   i_hit_side,
    input  wire signed [rwtc_pkg::DIR_W-1:0]      i_ray_dir_x,
    input  wire signed [rwtc_pkg::DIR_W-1:0]      i_ray_dir_y,
    input  wire  [rwtc_pkg::DIST_W-1:0]           i_wall_dist,
    input  wire  [rwtc_pkg::ROW_W-1:0]            i_span_start,
    input  wire  [rwtc_pkg::ROW_W-1:0]            i_span_end,
    input  wire  [rwtc_pkg::HEIGHT_W-1:0]         i_wall_height,
    input  wire  [rwtc_pkg::COL_W-1:0]            i_screen_col,
    input  wire                                   i_out_ready,
    output logic                                  o_out_valid,
    output logic [rwtc_pkg::SEL_W-1:0]            o_texture_id,
    output logic [rwtc_pkg::TEXEL_W-1:0]          o_texel_index,
    output logic [rwtc_pkg::COL_W-1:0]            o_pixel_x,
    output logic [rwtc_pkg::ROW_W-1:0]            o_pixel_y,
    output logic                                  o_last
);
    import rwtc_pkg::*;

    localparam int TW     = $clog2(TEX_SIZE);
    localparam int STEP_W = TW + FRAC_W + 1;
    localparam int PROD_W = FACTOR_W + STEP_W;
    localparam int CNT_W  = $clog2(STEP_W + 1);
    localparam logic [STEP_W-1:0] NUMER = {1'b1, {(STEP_W-1){1'b0}}};

    // configuration
    logic [POS_W-1:0] r_pos_x;
    logic [POS_W-1:0] r_pos_y;

    // captured column load
    logic                    r_side;
    logic signed [DIR_W-1:0] r_dx;
    logic signed [DIR_W-1:0] r_dy;
    logic [DIST_W-1:0]       r_dist;
    logic [HEIGHT_W-1:0]     r_h;

    // column state
    logic                       r_active;
    logic [TW-1:0]              r_tex_col;
    logic [STEP_W-1:0]          r_step;
    logic signed [PROD_W-1:0]   r_tex_pos;
    logic [ROW_W-1:0]           r_row;
    logic [ROW_W-1:0]           r_row_end;
    t_tex_id                    r_tex_sel;
    logic [COL_W-1:0]           r_column;

    // load pipeline and divider
    logic [HIT_W-1:0]            r_mul_lo;
    logic signed [FACTOR_W-1:0]  r_factor;
    logic [STEP_W-1:0]           r_quo;
    logic [REM_W-1:0]            r_rem;
    logic [CNT_W-1:0]            r_cnt;

    // output register
    logic                r_out_valid;
    t_tex_id             r_out_sel;
    logic [TEXEL_W-1:0]  r_out_texel;
    logic [COL_W-1:0]    r_out_x;
    logic [ROW_W-1:0]    r_out_y;
    logic                r_out_last;

    logic signed [DIR_W-1:0]          dir_sel;
    logic signed [DIST_W+DIR_W:0]     mul_full;
    logic signed [PROD_W:0]           pos_full;
    logic [POS_W-1:0]                 pos_sel;
    logic [HIT_W-1:0]                 frac;
    logic [TW-1:0]                    tx;
    logic                             dx_pos;
    logic                             dy_pos;
    logic                             mirror;
    logic [REM_W-1:0]                 trial;
    logic                             fits;
    logic                             neg_round;
    logic [TW-1:0]                    ty;
    logic                             fin;

    assign dir_sel  = r_side ? r_dx : r_dy;
    assign mul_full = $signed({1'b0, r_dist}) * dir_sel;
    assign pos_full = r_factor * $signed({1'b0, r_quo});
    assign pos_sel  = r_side ? r_pos_x : r_pos_y;
    assign frac     = {pos_sel[FRAC_W-1:0], {FRAC_W{1'b0}}} + r_mul_lo;
    assign dx_pos   = !r_dx[DIR_W-1] && (|r_dx);
    assign dy_pos   = !r_dy[DIR_W-1] && (|r_dy);
    assign mirror   = (!r_side && dx_pos) || (r_side && r_dy[DIR_W-1]);
    assign tx       = mirror ? ~frac[HIT_W-1 -: TW] : frac[HIT_W-1 -: TW];

    // restoring division of the constant TEX_SIZE<<16 by the line height
    assign trial = {r_rem[REM_W-2:0], r_quo[STEP_W-1]};
    assign fits  = (trial >= {1'b0, r_h});

    // integer part truncated toward zero: floor, plus one for a negative non-integer
    assign neg_round = r_tex_pos[PROD_W-1] && (|r_tex_pos[FRAC_W-1:0]);
    assign ty        = r_tex_pos[FRAC_W +: TW] + TW'(neg_round);
    assign fin       = (r_row == r_row_end);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_x <= '0;
            r_pos_y <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_idx))
                REG_PLAYER_POS_X: r_pos_x <= i_cfg_data[POS_W-1:0];
                REG_PLAYER_POS_Y: r_pos_y <= i_cfg_data[POS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
        end else if (i_cmd.load) begin
            r_active <= 1'b0;
        end else if (i_cmd.finish) begin
            r_active <= (r_row <= r_row_end);
        end else if (i_cmd.tick && fin) begin
            r_active <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_side    <= i_hit_side;
            r_dx      <= i_ray_dir_x;
            r_dy      <= i_ray_dir_y;
            r_dist    <= i_wall_dist;
            r_h       <= (i_wall_height == '0) ? HEIGHT_W'(1) : i_wall_height;
            r_row     <= i_span_start;
            r_row_end <= i_span_end;
            r_column  <= i_screen_col;
        end else if (i_cmd.tick && !fin) begin
            r_row <= r_row + ROW_W'(1);
        end

        if (i_cmd.mul) begin
            r_mul_lo <= mul_full[HIT_W-1:0];
            r_factor <= FACTOR_W'(r_row) - FACTOR_W'(SCREEN_HEIGHT / 2)
                        + FACTOR_W'(r_h >> 1);
            r_quo    <= NUMER;
            r_rem    <= '0;
            r_cnt    <= '0;
        end else if (i_cmd.div_step) begin
            r_rem <= fits ? (trial - {1'b0, r_h}) : trial;
            r_quo <= {r_quo[STEP_W-2:0], fits};
            r_cnt <= r_cnt + CNT_W'(1);
        end

        if (i_cmd.finish) begin
            r_step    <= r_quo;
            r_tex_pos <= pos_full[PROD_W-1:0];
            r_tex_col <= tx;
            if (!r_side) begin
                r_tex_sel <= dx_pos ? TEX_EAST : TEX_WEST;
            end else begin
                r_tex_sel <= dy_pos ? TEX_SOUTH : TEX_NORTH;
            end
        end else if (i_cmd.tick) begin
            r_tex_pos <= r_tex_pos + $signed({{(PROD_W-STEP_W){1'b0}}, r_step});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.tick) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.tick) begin
            r_out_sel   <= r_tex_sel;
            r_out_texel <= TEXEL_W'({ty, r_tex_col});
            r_out_x     <= r_column;
            r_out_y     <= r_row;
            r_out_last  <= fin;
        end
    end

    assign o_status.active   = r_active;
    assign o_status.div_last = (r_cnt == CNT_W'(STEP_W - 1));
    assign o_status.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid   = r_out_valid;
    assign o_texture_id  = r_out_sel;
    assign o_texel_index = r_out_texel;
    assign o_pixel_x     = r_out_x;
    assign o_pixel_y     = r_out_y;
    assign o_last        = r_out_last;
endmodule

`default_nettype wire

// ----- hdl/raycast_wall_texture_column_top.sv -----
// Textured wall column mapper for a raycaster.
// i_pix carries items: a column load (kind 0) sets up a span, a pixel tick
// (kind 1) emits one texel address on o_pix for the next row of that span,
// with last high on the final row. A tick while no span is active is taken
// and gives nothing; a load replaces any span in progress.
// i_cfg_we/i_cfg_idx/i_cfg_data write the player position between frames.
// Ticks: one item per cycle while the output register is free or being
// emptied, result in the output register in the cycle after acceptance.
// A load holds ready low while the block forms the hit product, runs the
// restoring step divider through all STEP_W quotient bits, then forms the
// starting texture position product.
// A stalled receiver holds the result in the output register; a tick is then
// taken in the same cycle the held result leaves.
// Synchronous reset clears the span, the output register and the player
// position; the block accepts items in the first cycle after reset.
`default_nettype none

module raycast_wall_texture_column_top #(
    parameter int TEX_SIZE = rwtc_pkg::TEX_SIZE_DEF
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_cfg_we,
    input  wire [rwtc_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire [rwtc_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    rwtc_in_if.sink                          i_pix,
    rwtc_out_if.source                       o_pix
);
    import rwtc_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;

    rwtc_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_pix.valid),
        .i_kind   (i_pix.kind),
        .o_ready  (i_pix.ready),
        .i_status (status),
        .o_cmd    (cmd)
    );

    rwtc_datapath #(
        .TEX_SIZE (TEX_SIZE)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_hit_side    (i_pix.hit_side),
        .i_ray_dir_x   (i_pix.ray_dir_x),
        .i_ray_dir_y   (i_pix.ray_dir_y),
        .i_wall_dist   (i_pix.wall_dist),
        .i_span_start  (i_pix.span_start),
        .i_span_end    (i_pix.span_end),
        .i_wall_height (i_pix.wall_height),
        .i_screen_col  (i_pix.screen_col),
        .i_out_ready   (o_pix.ready),
        .o_out_valid   (o_pix.valid),
        .o_texture_id  (o_pix.texture_id),
        .o_texel_index (o_pix.texel_index),
        .o_pixel_x     (o_pix.pixel_x),
        .o_pixel_y     (o_pix.pixel_y),
        .o_last        (o_pix.last)
    );

`ifndef ASSERT_OFF
    // input ready is low right after a column load
    a_load_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load |=> !i_pix.ready)
        else $error("input ready high right after a column load");

    a_load_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load |=> !status.active)
        else $error("span still active after a column load");

    // a new result only appears from an accepted tick
    a_out_from_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_pix.valid) |-> $past(cmd.tick))
        else $error("result appeared without a pixel tick");

    a_tick_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.tick |-> status.out_free)
        else $error("tick taken while the output register is full");
`endif
endmodule

`default_nettype wire

// ----- test/rwtc_texel_checker.sv -----
// texel predictor and scoreboard for the wall texture column mapper
module rwtc_texel_checker import rwtc_pkg::*; (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_cfg_we,
    input  wire [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire [CFG_DATA_W-1:0] i_cfg_data,
    rwtc_in_if                   pix_in,
    rwtc_out_if                  pix_out,
    output int                   o_errors,
    output int                   o_pending,
    output int                   o_texels_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TEX  = TEX_SIZE_DEF;
    localparam int TX_W = $clog2(TEX);

    typedef struct packed {
        logic [SEL_W-1:0]   tex_id;
        logic [TEXEL_W-1:0] texel;
        logic [COL_W-1:0]   px;
        logic [ROW_W-1:0]   py;
        logic               last;
    } t_texel;

    t_texel texel_due[$];

    int err_cnt     = 0;
    int pending_cnt = 0;
    int checked_cnt = 0;

    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
    logic             span_on;
    logic [TX_W-1:0]  tex_col;
    longint           tex_step;
    longint           tex_row_acc;
    logic [ROW_W-1:0] row_cur;
    logic [ROW_W-1:0] row_last;
    t_tex_id          tex_sel;
    logic [COL_W-1:0] scr_col;

    assign o_errors         = err_cnt;
    assign o_pending        = pending_cnt;
    assign o_texels_checked = checked_cnt;

    task automatic load_column();
        longint                  hgt;
        longint                  base;
        longint                  dir_v;
        longint                  hit;
        longint                  tx;
        logic signed [DIR_W-1:0] dx;
        logic signed [DIR_W-1:0] dy;
        logic [31:0]             frac;
        dx  = pix_in.ray_dir_x;
        dy  = pix_in.ray_dir_y;
        // zero height saturates to one
        hgt = (pix_in.wall_height == '0) ? 64'sd1 : longint'(pix_in.wall_height);
        if (pix_in.hit_side == 1'b0) begin
            base  = longint'(pos_y);
            dir_v = longint'(dy);
        end else begin
            base  = longint'(pos_x);
            dir_v = longint'(dx);
        end
        hit  = base * 65536 + longint'(pix_in.wall_dist) * dir_v;
        frac = hit[31:0];
        tx   = (longint'(frac) * TEX) >>> 32;
        // mirror the column for the facing cases
        if ((pix_in.hit_side == 1'b0 && dx > 0) || (pix_in.hit_side == 1'b1 && dy < 0))
            tx = TEX - tx - 1;
        tex_col = tx[TX_W-1:0];
        if (pix_in.hit_side == 1'b0)
            tex_sel = (dx > 0) ? TEX_EAST : TEX_WEST;
        else
            tex_sel = (dy > 0) ? TEX_SOUTH : TEX_NORTH;
        tex_step    = (longint'(TEX) * 65536) / hgt;
        tex_row_acc = (longint'(pix_in.span_start) - SCREEN_HEIGHT / 2 + hgt / 2) * tex_step;
        row_cur     = pix_in.span_start;
        row_last    = pix_in.span_end;
        scr_col     = pix_in.screen_col;
        span_on     = (pix_in.span_start <= pix_in.span_end);
    endtask

    task automatic tick_pixel();
        longint ty;
        t_texel due;
        if (span_on) begin
            // integer part truncated toward zero
            ty = (tex_row_acc >= 0) ? (tex_row_acc >>> 16) : -((-tex_row_acc) >>> 16);
            due.tex_id = tex_sel;
            due.texel  = TEXEL_W'((ty & (TEX - 1)) * TEX + tex_col);
            due.px     = scr_col;
            due.py     = row_cur;
            due.last   = (row_cur == row_last);
            texel_due.push_back(due);
            tex_row_acc += tex_step;
            if (due.last)
                span_on = 1'b0;
            else
                row_cur = row_cur + 1'b1;
        end
    endtask

    task automatic check_texel();
        t_texel got;
        t_texel want;
        got = {pix_out.texture_id, pix_out.texel_index, pix_out.pixel_x,
               pix_out.pixel_y, pix_out.last};
        if (texel_due.size() == 0) begin
            if (err_cnt < 10)
                $display("%0t: unexpected texel id %0d idx %0d x %0d y %0d last %0d",
                         $realtime, got.tex_id, got.texel, got.px, got.py, got.last);
            err_cnt++;
        end else begin
            want = texel_due.pop_front();
            checked_cnt++;
            if (got.tex_id !== want.tex_id || got.texel !== want.texel ||
                got.px !== want.px || got.py !== want.py || got.last !== want.last) begin
                if (err_cnt < 10) begin
                    $display("%0t: texel mismatch", $realtime);
                    $display("  want id %0d idx %0d x %0d y %0d last %0d",
                             want.tex_id, want.texel, want.px, want.py, want.last);
                    $display("  got  id %0d idx %0d x %0d y %0d last %0d",
                             got.tex_id, got.texel, got.px, got.py, got.last);
                end
                err_cnt++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pos_x       = '0;
            pos_y       = '0;
            span_on     = 1'b0;
            tex_col     = '0;
            tex_step    = 0;
            tex_row_acc = 0;
            row_cur     = '0;
            row_last    = '0;
            tex_sel     = TEX_EAST;
            scr_col     = '0;
            texel_due.delete();
        end else begin
            if (pix_out.valid && pix_out.ready)
                check_texel();
            if (i_cfg_we) begin
                if (i_cfg_idx == REG_PLAYER_POS_X)
                    pos_x = i_cfg_data[POS_W-1:0];
                else
                    pos_y = i_cfg_data[POS_W-1:0];
            end
            if (pix_in.valid && pix_in.ready) begin
                if (pix_in.kind == KIND_LOAD)
                    load_column();
                else
                    tick_pixel();
            end
        end
        pending_cnt = texel_due.size();
    end

endmodule

// ----- test/raycast_wall_texture_column_top_tb.sv -----
// stimulus and verdict for the wall texture column mapper
module raycast_wall_texture_column_top_tb import rwtc_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT       = 200000;
    localparam int HOLD_CYCLES = 300;
    localparam int HOLD_PHASE  = 3;
    localparam int DRAIN_GAP   = 30;
    localparam int TAIL        = 40;
    localparam int RAND_ITEMS  = 220;

    localparam logic signed [DIR_W-1:0] DIR_MAX = 18'sh1FFFF;
    localparam logic signed [DIR_W-1:0] DIR_MIN = 18'sh20000;

    typedef struct {
        t_kind                   kind;
        logic                    hit_side;
        logic signed [DIR_W-1:0] dir_x;
        logic signed [DIR_W-1:0] dir_y;
        logic [DIST_W-1:0]       wall_dist;
        logic [ROW_W-1:0]        row_first;
        logic [ROW_W-1:0]        row_final;
        logic [HEIGHT_W-1:0]     height;
        logic [COL_W-1:0]        col;
    } t_pix_item;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    int errors;
    int pending;
    int texels_checked;
    int cycle_cnt        = 0;
    int loads_sent       = 0;
    int ticks_sent       = 0;
    int idle_ticks_sent  = 0;
    int phase_no         = 0;
    bit gaps_on          = 1'b1;
    bit long_hold_done   = 1'b0;

    rwtc_in_if  pix_in ();
    rwtc_out_if pix_out ();

    raycast_wall_texture_column_top dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_pix      (pix_in),
        .o_pix      (pix_out)
    );

    rwtc_texel_checker u_texel_chk (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_cfg_we         (cfg_we),
        .i_cfg_idx        (cfg_idx),
        .i_cfg_data       (cfg_data),
        .pix_in           (pix_in),
        .pix_out          (pix_out),
        .o_errors         (errors),
        .o_pending        (pending),
        .o_texels_checked (texels_checked)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial begin
        while (cycle_cnt < LIMIT) begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("raycast_wall_texture_column_top_tb: errors");
        $finish;
    end

    // output side: random stalls, plus one long hold-off to back the block up
    initial begin
        pix_out.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            if (phase_no == HOLD_PHASE && !long_hold_done) begin
                long_hold_done = 1'b1;
                pix_out.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end else if (gaps_on && $urandom_range(0, 4) == 0) begin
                pix_out.ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge clk);
            end
            pix_out.ready <= 1'b1;
            @(posedge clk);
        end
    end

    function automatic t_pix_item rand_item();
        t_pix_item it;
        it.kind      = KIND_TICK;
        it.hit_side  = 1'($urandom_range(0, 1));
        it.dir_x     = DIR_W'($urandom);
        it.dir_y     = DIR_W'($urandom);
        it.wall_dist = DIST_W'($urandom);
        it.row_first = ROW_W'($urandom);
        it.row_final = ROW_W'($urandom);
        it.height    = HEIGHT_W'($urandom);
        it.col       = COL_W'($urandom);
        return it;
    endfunction

    function automatic logic signed [DIR_W-1:0] rand_dir();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            return '0;
        else if (pick == 1)
            return DIR_MAX;
        else if (pick == 2)
            return DIR_MIN;
        return DIR_W'($urandom);
    endfunction

    function automatic t_pix_item mk_load(input logic side,
                                          input logic signed [DIR_W-1:0] dx,
                                          input logic signed [DIR_W-1:0] dy,
                                          input logic [DIST_W-1:0] d,
                                          input int first, input int final_row,
                                          input int height, input int col);
        t_pix_item it;
        it.kind      = KIND_LOAD;
        it.hit_side  = side;
        it.dir_x     = dx;
        it.dir_y     = dy;
        it.wall_dist = d;
        it.row_first = ROW_W'(first);
        it.row_final = ROW_W'(final_row);
        it.height    = HEIGHT_W'(height);
        it.col       = COL_W'(col);
        return it;
    endfunction

    function automatic t_pix_item rand_load();
        t_pix_item it;
        int        len;
        int        first;
        int        pick;
        it       = rand_item();
        it.kind  = KIND_LOAD;
        it.dir_x = rand_dir();
        it.dir_y = rand_dir();
        pick = $urandom_range(0, 9);
        if (pick == 0)
            it.wall_dist = 24'h000000;
        else if (pick == 1)
            it.wall_dist = 24'hFFFFFF;
        else if (pick == 2)
            it.wall_dist = DIST_W'($urandom_range(0, 32'h3FFFF));
        // mostly short spans, the odd long one
        len  = ($urandom_range(0, 19) == 0) ? $urandom_range(30, 120) : $urandom_range(1, 12);
        pick = $urandom_range(0, 9);
        if (pick == 0)
            first = 0;
        else if (pick == 1)
            first = 1024 - len;
        else
            first = $urandom_range(0, 1024 - len);
        it.row_first = ROW_W'(first);
        it.row_final = ROW_W'(first + len - 1);
        pick = $urandom_range(0, 9);
        if (pick == 0)
            it.height = '0;
        else if (pick == 3)
            it.height = HEIGHT_W'($urandom_range(1, 8));
        else if (pick > 3)
            it.height = HEIGHT_W'($urandom_range(1, 2048));
        return it;
    endfunction

    task automatic offer(input t_pix_item it);
        if (gaps_on && $urandom_range(0, 4) == 0) begin
            pix_in.valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        pix_in.valid       <= 1'b1;
        pix_in.kind        <= it.kind;
        pix_in.hit_side    <= it.hit_side;
        pix_in.ray_dir_x   <= it.dir_x;
        pix_in.ray_dir_y   <= it.dir_y;
        pix_in.wall_dist   <= it.wall_dist;
        pix_in.span_start  <= it.row_first;
        pix_in.span_end    <= it.row_final;
        pix_in.wall_height <= it.height;
        pix_in.screen_col  <= it.col;
        @(posedge clk);
        while (!pix_in.ready) @(posedge clk);
        if (it.kind == KIND_LOAD)
            loads_sent++;
    endtask

    task automatic offer_tick(input bit in_span);
        offer(rand_item());
        if (in_span)
            ticks_sent++;
        else
            idle_ticks_sent++;
    endtask

    task automatic wait_drained();
        pix_in.valid <= 1'b0;
        do @(negedge clk); while (pending != 0);
        @(posedge clk);
    endtask

    // player position only changes with the block idle, divider included
    task automatic set_position(input logic [POS_W-1:0] x, input logic [POS_W-1:0] y);
        wait_drained();
        repeat (DRAIN_GAP) @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= REG_PLAYER_POS_X;
        cfg_data <= x;
        @(posedge clk);
        cfg_idx  <= REG_PLAYER_POS_Y;
        cfg_data <= y;
        @(posedge clk);
        cfg_we   <= 1'b0;
        phase_no++;
    endtask

    task automatic run_columns(input int target);
        t_pix_item it;
        int        counted;
        int        len;
        int        ticks;
        int        pick;
        int        cut;
        counted = 0;
        while (counted < target) begin
            it   = rand_load();
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                // span starts after its end: nothing becomes active
                cut          = $urandom_range(0, 1022);
                it.row_final = ROW_W'(cut);
                it.row_first = ROW_W'($urandom_range(cut + 1, 1023));
                offer(it);
                counted++;
                repeat ($urandom_range(1, 2)) offer_tick(1'b0);
            end else begin
                len   = int'(it.row_final) - int'(it.row_first) + 1;
                // some spans are cut short by the next load
                ticks = (pick < 20) ? $urandom_range(0, len - 1) : len;
                offer(it);
                repeat (ticks) offer_tick(1'b1);
                counted += 1 + ticks;
                if (pick >= 90)
                    repeat ($urandom_range(1, 3)) offer_tick(1'b0);
            end
        end
    endtask

    initial begin
        rst_n              <= 1'b0;
        cfg_we             <= 1'b0;
        cfg_idx            <= REG_PLAYER_POS_X;
        cfg_data           <= '0;
        pix_in.valid       <= 1'b0;
        pix_in.kind        <= KIND_LOAD;
        pix_in.hit_side    <= 1'b0;
        pix_in.ray_dir_x   <= '0;
        pix_in.ray_dir_y   <= '0;
        pix_in.wall_dist   <= '0;
        pix_in.span_start  <= '0;
        pix_in.span_end    <= '0;
        pix_in.wall_height <= '0;
        pix_in.screen_col  <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        set_position(24'hFFFFFF, 24'h000000);
        offer_tick(1'b0);
        offer(mk_load(1'b0, DIR_MAX, DIR_MIN, 24'hFFFFFF, 0, 2, 0, 0));
        repeat (3) offer_tick(1'b1);
        offer(mk_load(1'b0, DIR_MIN, DIR_MAX, 24'h000000, 1023, 1023, 65535, 2047));
        offer_tick(1'b1);
        offer_tick(1'b0);
        offer(mk_load(1'b1, '0, DIR_MIN, 24'h012345, 5, 4, 64, 1000));
        offer_tick(1'b0);
        offer(mk_load(1'b1, DIR_MAX, DIR_MAX, 24'h800000, 510, 513, 1, 77));
        repeat (2) offer_tick(1'b1);
        // load in mid-span replaces it
        offer(mk_load(1'b1, -18'sd1, '0, 24'h000001, 0, 1, 2, 1));
        repeat (2) offer_tick(1'b1);
        offer(mk_load(1'b0, '0, 18'sd1, 24'h7FFFFF, 1020, 1023, 1024, 1024));
        repeat (4) offer_tick(1'b1);

        set_position(24'h000000, 24'h000000);
        run_columns(RAND_ITEMS);
        set_position(24'hFFFFFF, 24'hFFFFFF);
        run_columns(RAND_ITEMS);
        set_position(POS_W'($urandom), POS_W'($urandom));
        run_columns(RAND_ITEMS);
        set_position(POS_W'($urandom), POS_W'($urandom));
        run_columns(RAND_ITEMS);
        gaps_on = 1'b0;
        set_position(POS_W'($urandom), POS_W'($urandom));
        run_columns(RAND_ITEMS);

        wait_drained();
        repeat (TAIL) @(posedge clk);
        $display("sent %0d column loads, %0d pixel ticks in span, %0d with no span; %0d texels",
                 loads_sent, ticks_sent, idle_ticks_sent, texels_checked);
        $display("six player positions incl. range ends, one %0d-cycle output hold-off",
                 HOLD_CYCLES);
        if (errors == 0)
            $display("raycast_wall_texture_column_top_tb: clean");
        else
            $display("raycast_wall_texture_column_top_tb: errors");
        $finish;
    end

endmodule
